// File: sv/quickselect_kth_smallest_assert.svh
// Assertion macros for the k-th smallest selector
`ifndef QUICKSELECT_KTH_SMALLEST_ASSERT_SVH
`define QUICKSELECT_KTH_SMALLEST_ASSERT_SVH

// same-cycle implication
`define QKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QKS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/qks_pkg.sv
// Shared types and constants of the k-th smallest selector
`default_nettype none
package qks_pkg;

  localparam int RANK_W = 7;
  localparam int KIDX_W = 6;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_RANK = 2'd1,
    STAT_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PIV,
    ST_PIV_LD,
    ST_SCAN,
    ST_CMP,
    ST_SWAP_WR,
    ST_FIN_RD,
    ST_FIN_WR,
    ST_FIN_PV,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: sv/qks_ifs.sv
// Channel interfaces of the k-th smallest selector
`default_nettype none
interface qks_in_if #(parameter int DATA_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] value;
  logic                  is_last;
  modport source (output valid, value, is_last, input ready);
  modport sink (input valid, value, is_last, output ready);
endinterface

interface qks_out_if #(parameter int DATA_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] kth_value;
  logic [5:0]            kth_index;
  logic [1:0]            status;
  modport source (output valid, kth_value, kth_index, status, input ready);
  modport sink (input valid, kth_value, kth_index, status, output ready);
endinterface

interface qks_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] target_rank;
  modport source (output valid, target_rank, input ready);
  modport sink (input valid, target_rank, output ready);
endinterface
`default_nettype wire

// File: sv/qks_store.sv
// Element store: one write port, two registered read ports
`default_nettype none
module qks_store #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [IW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic [IW-1:0]         raddr_a,
  input  wire logic [IW-1:0]         raddr_b,
  output logic      [DATA_WIDTH-1:0] rdata_a,
  output logic      [DATA_WIDTH-1:0] rdata_b
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_a_r;
  logic [DATA_WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule
`default_nettype wire

// File: sv/qks_seq.sv
// Load and partition sequencer with shared compare unit and result register
`default_nettype none
module qks_seq import qks_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  input  wire logic                  in_is_last,
  input  wire logic [RANK_W-1:0]     target_rank,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [DATA_WIDTH-1:0] out_kth_value,
  output logic      [KIDX_W-1:0]     out_kth_index,
  output status_t                    out_status,
  output logic                       mem_we,
  output logic      [IW-1:0]         mem_waddr,
  output logic      [DATA_WIDTH-1:0] mem_wdata,
  output logic      [IW-1:0]         mem_raddr_a,
  output logic      [IW-1:0]         mem_raddr_b,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata_a,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata_b
);

  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [IW-1:0]         lo_r, lo_nxt;
  logic [IW-1:0]         hi_r, hi_nxt;
  logic [IW-1:0]         p_r, p_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic [IW-1:0]         want_r, want_nxt;
  logic [DATA_WIDTH-1:0] piv_r, piv_nxt;
  logic [DATA_WIDTH-1:0] swap_r, swap_nxt;
  status_t               status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic [KIDX_W-1:0]     out_index_r, out_index_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  full;
  logic [CW-1:0]         cnt_new;
  logic                  le_hit;
  logic [IW-1:0]         p_inc;
  logic [IW-1:0]         i_inc;

  assign full    = (cnt_r == CW'(DEPTH));
  assign cnt_new = full ? cnt_r : CW'(cnt_r + 1'b1);
  assign le_hit  = ($signed(mem_rdata_a) <= $signed(piv_r));
  assign p_inc   = IW'(p_r + 1'b1);
  assign i_inc   = IW'(i_r + 1'b1);

  assign in_ready      = (state_r == ST_LOAD);
  assign out_valid     = out_valid_r;
  assign out_kth_value = out_value_r;
  assign out_kth_index = out_index_r;
  assign out_status    = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    i_r          <= i_nxt;
    want_r       <= want_nxt;
    piv_r        <= piv_nxt;
    swap_r       <= swap_nxt;
    status_r     <= status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    p_nxt          = p_r;
    i_nxt          = i_r;
    want_nxt       = want_r;
    piv_nxt        = piv_r;
    swap_nxt       = swap_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = p_inc;
    mem_wdata      = mem_rdata_a;
    mem_raddr_a    = lo_r;
    mem_raddr_b    = p_inc;

    case (state_r)
      ST_LOAD: begin
        mem_waddr = cnt_r[IW-1:0];
        mem_wdata = in_value;
        if (in_valid) begin
          mem_we  = !full;
          cnt_nxt = cnt_new;
          ovf_nxt = ovf_r || full;
          if (in_is_last) begin
            lo_nxt   = '0;
            hi_nxt   = IW'(cnt_new - 1'b1);
            want_nxt = IW'(target_rank - 1'b1);
            if (ovf_r || full) begin
              status_nxt = STAT_OVF;
              state_nxt  = ST_EMIT;
            end else if (target_rank == '0 ||
                         CMPW'(target_rank) > CMPW'(cnt_new)) begin
              status_nxt = STAT_RANK;
              state_nxt  = ST_EMIT;
            end else begin
              status_nxt = STAT_OK;
              state_nxt  = ST_PIV;
            end
          end
        end
      end
      ST_PIV: begin
        mem_raddr_a = lo_r;
        state_nxt   = ST_PIV_LD;
      end
      ST_PIV_LD: begin
        piv_nxt = mem_rdata_a;
        p_nxt   = lo_r;
        i_nxt   = IW'(lo_r + 1'b1);
        state_nxt = (lo_r == hi_r) ? ST_FIN_RD : ST_SCAN;
      end
      ST_SCAN: begin
        mem_raddr_a = i_r;
        mem_raddr_b = p_inc;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        if (le_hit) begin
          mem_we    = 1'b1;
          mem_waddr = p_inc;
          mem_wdata = mem_rdata_a;
          swap_nxt  = mem_rdata_b;
          p_nxt     = p_inc;
          state_nxt = ST_SWAP_WR;
        end else if (i_r == hi_r) begin
          state_nxt = ST_FIN_RD;
        end else begin
          i_nxt     = i_inc;
          state_nxt = ST_SCAN;
        end
      end
      ST_SWAP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = swap_r;
        if (i_r == hi_r) begin
          state_nxt = ST_FIN_RD;
        end else begin
          i_nxt     = i_inc;
          state_nxt = ST_SCAN;
        end
      end
      ST_FIN_RD: begin
        mem_raddr_a = p_r;
        state_nxt   = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = mem_rdata_a;
        state_nxt = ST_FIN_PV;
      end
      ST_FIN_PV: begin
        mem_we    = 1'b1;
        mem_waddr = p_r;
        mem_wdata = piv_r;
        if (p_r == want_r) begin
          state_nxt = ST_EMIT;
        end else if (p_r < want_r) begin
          lo_nxt    = p_inc;
          state_nxt = ST_PIV;
        end else begin
          hi_nxt    = IW'(p_r - 1'b1);
          state_nxt = ST_PIV;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = (status_r == STAT_OK) ? piv_r : '0;
          out_index_nxt  = (status_r == STAT_OK) ? KIDX_W'(p_r) : '0;
          cnt_nxt        = '0;
          ovf_nxt        = 1'b0;
          lo_nxt         = '0;
          hi_nxt         = '0;
          state_nxt      = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/quickselect_kth_smallest.sv
// K-th smallest selector: load a set, quickselect with Lomuto partition
// Loading accepts one item per cycle; in_ready stays high while loading.
// After the last item, each pass loads the pivot, reads and compares each element,
// swaps those moved left and places the pivot, all via the single compare unit.
// Error results (rank out of range, store overflow) go straight to the emit state.
// Reset clears the sequencer, counts and result valid; store is not cleared.
`default_nettype none
`include "quickselect_kth_smallest_assert.svh"
module quickselect_kth_smallest import qks_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  qks_in_if.sink    in_if,
  qks_out_if.source out_if,
  qks_cfg_if.sink   cfg_if
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [RANK_W-1:0]     target_rank_r;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [IW-1:0]         mem_raddr_a;
  logic [IW-1:0]         mem_raddr_b;
  logic [DATA_WIDTH-1:0] mem_rdata_a;
  logic [DATA_WIDTH-1:0] mem_rdata_b;
  status_t               status;
  logic                  last_xfer;
  logic                  err_out;
  logic                  payload_zero;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_rank_r <= RANK_W'(1);
    end else if (cfg_if.valid) begin
      target_rank_r <= cfg_if.target_rank;
    end
  end

  qks_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  qks_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IW         (IW),
    .CW         (CW)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_value      (in_if.value),
    .in_is_last    (in_if.is_last),
    .target_rank   (target_rank_r),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_kth_value (out_if.kth_value),
    .out_kth_index (out_if.kth_index),
    .out_status    (status),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr_a   (mem_raddr_a),
    .mem_raddr_b   (mem_raddr_b),
    .mem_rdata_a   (mem_rdata_a),
    .mem_rdata_b   (mem_rdata_b)
  );

  assign out_if.status = status;

  assign last_xfer    = in_if.valid && in_if.ready && in_if.is_last;
  assign err_out      = out_if.valid && (status != STAT_OK);
  assign payload_zero = (out_if.kth_value == '0) && (out_if.kth_index == '0);

  `QKS_ASSERT_NXT(a_busy_after_last, clk, rst_n, last_xfer, !in_if.ready, "input ready after last")
  `QKS_ASSERT_NOW(a_error_zero, clk, rst_n, err_out, payload_zero, "error result not zero")

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the k-th smallest selector: random and directed sets against a quickselect model
module tb_top;
  import qks_pkg::*;

  localparam int DEPTH        = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRINT_CAP    = 20;

  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_RISING,
    FILL_FALLING
  } fill_style_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] kth_value;
    logic [5:0]            kth_index;
    status_t               status;
  } kth_result_t;

  logic clk;
  logic rst_n;

  qks_in_if #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
  qks_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_ch ();
  qks_cfg_if cfg_ch ();

  quickselect_kth_smallest #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int items_sent = 0;

  logic signed [DATA_WIDTH-1:0] sel_store [DEPTH];
  int          sel_count;
  bit          sel_overflow;
  logic [6:0]  sel_rank;
  kth_result_t kth_expected [$];
  kth_result_t oldest_kth;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("quickselect_kth_smallest test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic report_mismatch(string what, longint want, longint got);
    if (fail_count < PRINT_CAP)
      $display("MISMATCH at cycle %0d, %s: expected %0d, got %0d",
               cycle_count, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (kth_expected.size() == 0) begin
        report_mismatch("result with none pending", 0, $signed(out_ch.kth_value));
      end else begin
        oldest_kth = kth_expected.pop_front();
        if (out_ch.kth_value !== oldest_kth.kth_value)
          report_mismatch("kth_value", $signed(oldest_kth.kth_value),
                          $signed(out_ch.kth_value));
        if (out_ch.kth_index !== oldest_kth.kth_index)
          report_mismatch("kth_index", oldest_kth.kth_index, out_ch.kth_index);
        if (out_ch.status !== oldest_kth.status)
          report_mismatch("status", oldest_kth.status, out_ch.status);
      end
    end
  end

  function automatic int lomuto_split(int lo, int hi);
    logic signed [DATA_WIDTH-1:0] piv;
    logic signed [DATA_WIDTH-1:0] tmp;
    int p;
    piv = sel_store[lo];
    p = lo;
    for (int i = lo + 1; i <= hi; i++) begin
      if (sel_store[i] <= piv) begin
        p++;
        tmp = sel_store[i];
        sel_store[i] = sel_store[p];
        sel_store[p] = tmp;
      end
    end
    tmp = sel_store[p];
    sel_store[p] = sel_store[lo];
    sel_store[lo] = tmp;
    return p;
  endfunction

  function automatic void predict_kth(logic [DATA_WIDTH-1:0] value, logic is_last);
    kth_result_t r;
    int want;
    int lo;
    int hi;
    int p;
    if (sel_count < DEPTH) begin
      sel_store[sel_count] = value;
      sel_count++;
    end else begin
      sel_overflow = 1'b1;
    end
    if (!is_last)
      return;
    r = '0;
    r.status = STAT_OK;
    if (sel_overflow) begin
      r.status = STAT_OVF;
    end else if (sel_rank == 0 || sel_rank > sel_count) begin
      r.status = STAT_RANK;
    end else begin
      want = sel_rank - 1;
      lo = 0;
      hi = sel_count - 1;
      forever begin
        p = lomuto_split(lo, hi);
        if (p == want)
          break;
        else if (p < want)
          lo = p + 1;
        else
          hi = p - 1;
      end
      r.kth_value = sel_store[want];
      r.kth_index = want[5:0];
    end
    kth_expected.push_back(r);
    sel_count = 0;
    sel_overflow = 1'b0;
  endfunction

  task automatic send_value(logic [DATA_WIDTH-1:0] value, logic is_last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= value;
    in_ch.is_last <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    predict_kth(value, is_last);
    items_sent++;
    @(negedge clk);
  endtask

  // hold the input idle until every pending result has transferred
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (kth_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rank(logic [6:0] rank);
    drain_results();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.target_rank <= rank;
    do @(posedge clk); while (!cfg_ch.ready);
    sel_rank = rank;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_set(int size, fill_style_t style);
    logic [DATA_WIDTH-1:0] base;
    logic [DATA_WIDTH-1:0] v;
    base = $urandom_range(100000);
    for (int i = 0; i < size; i++) begin
      case (style)
        FILL_NARROW: v = int'($urandom_range(6)) - 3;
        FILL_RISING: v = base + i;
        FILL_FALLING: v = base - i;
        default: v = $urandom;
      endcase
      send_value(v, i == size - 1);
    end
  endtask

  task automatic test_directed();
    write_rank(7'd1);
    send_value(32'h7fff_ffff, 1'b1);
    write_rank(7'd3);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'h0000_0001, 1'b1);
    send_value(32'd5, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(-32'sd5, 1'b0);
    send_value(32'd5, 1'b1);
    write_rank(7'd0);
    send_value(32'd1, 1'b0);
    send_value(32'd2, 1'b1);
    write_rank(7'd4);
    send_value(32'd9, 1'b0);
    send_value(32'd8, 1'b0);
    send_value(32'd7, 1'b1);
    write_rank(7'd127);
    send_value(32'd3, 1'b1);
  endtask

  task automatic test_full_store();
    write_rank(7'd64);
    send_set(DEPTH, FILL_FALLING);
    send_set(DEPTH, FILL_RANDOM);
    write_rank(7'd1);
    send_set(DEPTH, FILL_RISING);
    write_rank(7'd2);
    send_set(DEPTH + 1, FILL_RANDOM);
    send_set(DEPTH + 3, FILL_NARROW);
  endtask

  task automatic test_paused_sets();
    write_rank(7'd2);
    for (int s = 0; s < 5; s++) begin
      send_set($urandom_range(2, 8), FILL_RANDOM);
      drain_results();
    end
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int item_budget);
    int stop_at;
    int pick;
    int size;
    logic [6:0] rank;
    fill_style_t style;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 4)
        rank = 7'd0;
      else if (pick < 7)
        rank = 7'd64;
      else if (pick < 9)
        rank = 7'($urandom_range(65, 127));
      else
        rank = 7'($urandom_range(1, 12));
      write_rank(rank);
      for (int s = 0; s < 4; s++) begin
        pick = $urandom_range(99);
        if (pick < 88)
          size = (rank == 0) ? $urandom_range(1, 10) : rank + $urandom_range(0, 10);
        else if (pick < 96)
          size = $urandom_range(1, 20);
        else
          size = $urandom_range(1, DEPTH + 6);
        if (size > DEPTH + 6)
          size = DEPTH + 6;
        pick = $urandom_range(99);
        if (size > 24 && pick < 90)
          style = FILL_RANDOM;
        else if (pick < 50)
          style = FILL_RANDOM;
        else if (pick < 75)
          style = FILL_NARROW;
        else if (pick < 87)
          style = FILL_RISING;
        else
          style = FILL_FALLING;
        send_set(size, style);
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.value        = '0;
    in_ch.is_last      = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.target_rank = '0;
    out_ch.ready       = 1'b0;
    sel_count          = 0;
    sel_overflow       = 1'b0;
    sel_rank           = 7'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    in_idle_pct = 32;
    out_stall_pct = 32;
    test_full_store();
    test_paused_sets();
    test_random(0, 0, 300);
    test_random(86, 0, 300);
    test_random(0, 86, 300);
    test_random(32, 32, 300);

    drain_results();
    if (fail_count == 0)
      $display("quickselect_kth_smallest test passed");
    else
      $display("quickselect_kth_smallest test failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/qks_pkg.sv
sv/qks_ifs.sv
sv/qks_store.sv
sv/qks_seq.sv
sv/quickselect_kth_smallest.sv
sim/tb_top.sv
